/* rtl/matrix_vector_multiply_core_macros.svh */
// Assertion helpers; clock and reset are taken from the enclosing module.
`ifndef MATRIX_VECTOR_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MVM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("mvm assertion failed");
`define MVM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mvm assertion failed");
`else
`define MVM_ASSERT(label, prop)
`define MVM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/mvm_pkg.sv */
package mvm_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 4096;
   localparam int ELEM_WIDTH  = 16;
   localparam int COL_AW      = $clog2(MAX_COLS);
   localparam int ROW_AW      = $clog2(MAX_ROWS);
   localparam int NUM_COLS_W  = 11;
   localparam int NUM_ROWS_W  = 13;
   localparam int PROD_W      = 2 * ELEM_WIDTH;
   localparam int ACC_W       = 48;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1) + 1;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_PAD_W   = RSP_TDATA_W - ACC_W - ROW_AW;

   typedef enum logic [0:0] {
      REQ_VECTOR = 1'b0,
      REQ_MATRIX = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS = 1'b0,
      CSR_NUM_COLS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ELEM_WIDTH-1:0] value;
      logic [ELEM_WIDTH-1:0] xval;
      logic                  eor;
      logic [ROW_AW-1:0]     row_index;
      logic                  last_row;
   } mac_op_type;

endpackage

/* rtl/mvm_ram.sv */
module mvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/mvm_front.sv */
module mvm_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_type,
   input  logic [mvm_pkg::ELEM_WIDTH-1:0]  req_value,
   input  logic                            csr_we,
   input  logic [mvm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [mvm_pkg::QUEUE_CW-1:0]    q_count,
   output logic                            q_push,
   output mvm_pkg::mac_op_type             q_data
);
   import mvm_pkg::*;

   logic [NUM_ROWS_W-1:0] num_rows_ff, num_rows_in;
   logic [NUM_COLS_W-1:0] num_cols_ff, num_cols_in;
   logic [COL_AW-1:0]     load_ptr_ff, load_ptr_in;
   logic [COL_AW-1:0]     col_ff, col_in;
   logic [ROW_AW-1:0]     row_ff, row_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [ELEM_WIDTH-1:0] s1_value_ff, s1_value_in;
   logic                  s1_eor_ff, s1_eor_in;
   logic [ROW_AW-1:0]     s1_row_ff, s1_row_in;
   logic                  s1_last_ff, s1_last_in;

   logic [NUM_COLS_W-1:0] cols;
   logic [NUM_ROWS_W-1:0] rows;
   logic                  accept;
   logic                  is_load;
   logic                  load_wrap;
   logic                  col_end;
   logic                  row_last;
   logic [ELEM_WIDTH-1:0] xval;

   always_comb begin
      if (num_cols_ff == '0) begin
         cols = NUM_COLS_W'(1);
      end else if (num_cols_ff > NUM_COLS_W'(MAX_COLS)) begin
         cols = NUM_COLS_W'(MAX_COLS);
      end else begin
         cols = num_cols_ff;
      end
      if (num_rows_ff == '0) begin
         rows = NUM_ROWS_W'(1);
      end else if (num_rows_ff > NUM_ROWS_W'(MAX_ROWS)) begin
         rows = NUM_ROWS_W'(MAX_ROWS);
      end else begin
         rows = num_rows_ff;
      end
   end

   assign req_tready = (q_count + QUEUE_CW'(s1_valid_ff)) < QUEUE_CW'(QUEUE_DEPTH);
   assign accept     = req_tvalid & req_tready;
   assign is_load    = (req_kind_type'(req_type) == REQ_VECTOR);
   assign load_wrap  = (NUM_COLS_W'(load_ptr_ff) + NUM_COLS_W'(1)) >= cols;
   assign col_end    = (NUM_COLS_W'(col_ff) + NUM_COLS_W'(1)) >= cols;
   assign row_last   = (NUM_ROWS_W'(row_ff) + NUM_ROWS_W'(1)) >= rows;

   mvm_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (MAX_COLS)
   ) u_vector_ram (
      .clock (clock),
      .we    (accept & is_load),
      .waddr (load_ptr_ff),
      .wdata (req_value),
      .raddr (col_ff),
      .rdata (xval)
   );

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_ROWS: num_rows_in = csr_wdata;
            CSR_NUM_COLS: num_cols_in = csr_wdata[NUM_COLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      load_ptr_in = load_ptr_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = accept & ~is_load;
      s1_value_in = req_value;
      s1_eor_in   = col_end;
      s1_row_in   = row_ff;
      s1_last_in  = row_last;
      if (accept) begin
         if (is_load) begin
            load_ptr_in = load_wrap ? '0 : load_ptr_ff + COL_AW'(1);
         end else if (col_end) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_AW'(1);
         end else begin
            col_in = col_ff + COL_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= NUM_ROWS_W'(1);
         num_cols_ff <= NUM_COLS_W'(1);
         load_ptr_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
         load_ptr_ff <= load_ptr_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_value_ff <= s1_value_in;
      s1_eor_ff   <= s1_eor_in;
      s1_row_ff   <= s1_row_in;
      s1_last_ff  <= s1_last_in;
   end

   assign q_push           = s1_valid_ff;
   assign q_data.value     = s1_value_ff;
   assign q_data.xval      = xval;
   assign q_data.eor       = s1_eor_ff;
   assign q_data.row_index = s1_row_ff;
   assign q_data.last_row  = s1_last_ff;

endmodule

/* rtl/mvm_fifo.sv */
`include "matrix_vector_multiply_core_macros.svh"

module mvm_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  mvm_pkg::mac_op_type          din,
   input  logic                         pop,
   output mvm_pkg::mac_op_type          dout,
   output logic                         empty,
   output logic [mvm_pkg::QUEUE_CW-1:0] count
);
   import mvm_pkg::*;

   mac_op_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in;
   logic [QUEUE_AW-1:0]   rd_ff, rd_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  full;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign count = count_ff;
   assign dout  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + QUEUE_AW'(1) : wr_ff;
      rd_in    = pop ? rd_ff + QUEUE_AW'(1) : rd_ff;
      count_in = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

   `MVM_ASSERT(a_no_overflow, !(push && full && !pop))
   `MVM_ASSERT(a_no_underflow, !(pop && empty))
   `MVM_ASSERT_NEXT(a_drain_empty, pop && !push && count_ff == QUEUE_CW'(1), empty)

endmodule

/* rtl/mvm_back.sv */
`include "matrix_vector_multiply_core_macros.svh"

module mvm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  mvm_pkg::mac_op_type           q_data,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mvm_pkg::ACC_W-1:0]     row_sum,
   output logic [mvm_pkg::ROW_AW-1:0]    row_index,
   output logic                          last_row
);
   import mvm_pkg::*;

   logic                  m_valid_ff, m_valid_in;
   logic [PROD_W-1:0]     m_prod_ff, m_prod_in;
   logic                  m_eor_ff, m_eor_in;
   logic [ROW_AW-1:0]     m_row_ff, m_row_in;
   logic                  m_last_ff, m_last_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic                  out_valid_ff, out_valid_in;
   logic [ACC_W-1:0]      out_sum_ff, out_sum_in;
   logic [ROW_AW-1:0]     out_row_ff, out_row_in;
   logic                  out_last_ff, out_last_in;

   logic                  stall;
   logic                  m_adv;
   logic                  retire;
   logic [ACC_W-1:0]      sum;

   assign stall  = out_valid_ff & ~rsp_tready;
   assign m_adv  = ~m_valid_ff | ~(m_eor_ff & stall);
   assign q_pop  = ~q_empty & m_adv;
   assign retire = m_valid_ff & m_adv;
   assign sum    = acc_ff + {{(ACC_W - PROD_W){m_prod_ff[PROD_W-1]}}, m_prod_ff};

   always_comb begin
      m_valid_in = m_adv ? q_pop : m_valid_ff;
      m_prod_in  = m_prod_ff;
      m_eor_in   = m_eor_ff;
      m_row_in   = m_row_ff;
      m_last_in  = m_last_ff;
      if (q_pop) begin
         m_prod_in = PROD_W'($signed(q_data.value) * $signed(q_data.xval));
         m_eor_in  = q_data.eor;
         m_row_in  = q_data.row_index;
         m_last_in = q_data.last_row;
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_sum_in   = out_sum_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;
      if (retire) begin
         if (m_eor_ff) begin
            acc_in       = '0;
            out_valid_in = 1'b1;
            out_sum_in   = sum;
            out_row_in   = m_row_ff;
            out_last_in  = m_last_ff;
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_prod_ff   <= m_prod_in;
      m_eor_ff    <= m_eor_in;
      m_row_ff    <= m_row_in;
      m_last_ff   <= m_last_in;
      out_sum_ff  <= out_sum_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign row_sum    = out_sum_ff;
   assign row_index  = out_row_ff;
   assign last_row   = out_last_ff;

   `MVM_ASSERT_NEXT(a_row_emits, retire && m_eor_ff, out_valid_ff)
   `MVM_ASSERT_NEXT(a_acc_clears, retire && m_eor_ff, acc_ff == '0)
   `MVM_ASSERT_NEXT(a_mac_holds, m_valid_ff && !m_adv, m_valid_ff && m_eor_ff)

endmodule

/* rtl/matrix_vector_multiply_core.sv */
// Fixed-point matrix-vector product b = A*x.
// req_ beats: tuser = 0 loads the next x element (pointer wraps at num_cols),
// tuser = 1 streams A row-major. tdata holds the signed element (12 fraction bits).
// rsp_ beats: one per matrix row, carrying the 48-bit row sum (24 fraction bits)
// and the row index; tlast marks the final row of the matrix.
// csr_: csr_index 0 = num_rows, 1 = num_cols; write only while idle.
// Throughput: one req_ beat per cycle, loads and matrix beats alike, while the
// queue has room; one multiply-accumulate per cycle in the back end, set by the
// 48-bit accumulator feedback path, unless a row end waits on a stalled rsp_.
// A row's result reaches rsp_ after its last beat passes the vector RAM read,
// the queue, the multiply register and the accumulation into the output register.
// Reset: sizes return to 1x1, pointers, counters and accumulator clear; the
// vector RAM keeps no reset and must be loaded before use.
// A stalled rsp_ side holds the result; the 4-entry queue keeps taking
// beats until it fills, then req_tready drops.
module matrix_vector_multiply_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // value
   input  logic                            req_tuser,  // req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mvm_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // row_sum, row_index, zero pad
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [mvm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mvm_pkg::*;

   mac_op_type            q_in;
   mac_op_type            q_out;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_empty;
   logic [QUEUE_CW-1:0]   q_count;
   logic [ACC_W-1:0]      row_sum;
   logic [ROW_AW-1:0]     row_index;

   mvm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .req_value  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   mvm_fifo u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_in),
      .pop   (q_pop),
      .dout  (q_out),
      .empty (q_empty),
      .count (q_count)
   );

   mvm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_out),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .row_sum    (row_sum),
      .row_index  (row_index),
      .last_row   (rsp_tlast)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, row_index, row_sum};

endmodule
